/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
// Depends on nothing; bodies vanish when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_AFTER(label, ck, rn, ante, n, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##n (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ck, rn, ante, cons)
`define ASSERT_AFTER(label, ck, rn, ante, n, cons)
`endif
`endif

/* rtl/qrp_pkg.sv */
// Constants and elaboration-time helpers for the quaternion to roll/pitch block.
// Depends on nothing.
package qrp_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 14;
    localparam int OUT_FRAC         = 13;
    localparam int ROLL_MAX         = 25736;
    localparam int PITCH_MAX        = 12868;
    localparam int SQRT_STEPS       = 29;   // root bits 28 down to 0
    localparam int SQ_W             = 59;   // remainder / trial width
    localparam int S_W              = 30;   // saturated asin argument, Q28
    localparam int VEC_W            = 38;   // CORDIC vector width, Q28 scale
    localparam logic signed [63:0] PI_QUARTER_Q60 = 64'sh0C90FDAA22168C23;

    // shift-subtract division, constants only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [63:0] atan_q60(input int i);
        logic signed [63:0] acc;
        logic signed [63:0] t;
        int e;
        acc = '0;
        if (i == 0) begin
            return PI_QUARTER_Q60;
        end
        for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 60) begin
                t = signed'(udiv64(64'd1 << (60 - e), 64'(2 * k + 1)));
                if (k % 2 == 1) acc = acc - t;
                else acc = acc + t;
            end
        end
        return acc;
    endfunction

    function automatic logic signed [63:0] round_q60(input logic signed [63:0] q, input int fb);
        logic signed [63:0] one;
        one = 64'sd1;
        return (q + (one <<< (59 - fb))) >>> (60 - fb);
    endfunction

endpackage

/* rtl/qrp_sqrt_cell.sv */
// One digit of the pipelined floor square root; carries the asin argument along.
// Depends on qrp_pkg.
module qrp_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                                clk,
    input  logic [qrp_pkg::SQ_W-1:0]            rem_in,
    input  logic [qrp_pkg::SQRT_STEPS-1:0]      root_in,
    input  logic signed [qrp_pkg::S_W-1:0]      s_in,
    output logic [qrp_pkg::SQ_W-1:0]            rem_reg,
    output logic [qrp_pkg::SQRT_STEPS-1:0]      root_reg,
    output logic signed [qrp_pkg::S_W-1:0]      s_reg
);
    logic [qrp_pkg::SQ_W-1:0] trial;
    logic                     ge;

    // root bits at and below BIT are still zero, so OR acts as add
    assign trial = (qrp_pkg::SQ_W'(root_in) << (BIT + 1))
                 | (qrp_pkg::SQ_W'(1) << (2 * BIT));
    assign ge = rem_in >= trial;

    always_ff @(posedge clk)
    begin
        rem_reg  <= ge ? rem_in - trial : rem_in;
        root_reg <= root_in | (qrp_pkg::SQRT_STEPS'(ge) << BIT);
        s_reg    <= s_in;
    end
endmodule

/* rtl/qrp_cordic_cell.sv */
// One vectoring CORDIC rotation: turn toward y = 0 and accumulate the angle.
// Depends on qrp_pkg.
module qrp_cordic_cell #(
    parameter int                 ANG_W    = 18,
    parameter int                 SHIFT    = 0,
    parameter logic signed [63:0] ATAN_VAL = 64'sd0
) (
    input  logic                              clk,
    input  logic signed [qrp_pkg::VEC_W-1:0]  x_in,
    input  logic signed [qrp_pkg::VEC_W-1:0]  y_in,
    input  logic signed [ANG_W-1:0]           z_in,
    input  logic                              zero_in,
    output logic signed [qrp_pkg::VEC_W-1:0]  x_reg,
    output logic signed [qrp_pkg::VEC_W-1:0]  y_reg,
    output logic signed [ANG_W-1:0]           z_reg,
    output logic                              zero_reg
);
    localparam logic signed [ANG_W-1:0] ATAN = ATAN_VAL[ANG_W-1:0];

    logic signed [qrp_pkg::VEC_W-1:0] dx;
    logic signed [qrp_pkg::VEC_W-1:0] dy;

    assign dx = y_in >>> SHIFT;
    assign dy = x_in >>> SHIFT;

    always_ff @(posedge clk)
    begin
        // zero y counts as positive
        if (y_in[qrp_pkg::VEC_W-1])
        begin
            x_reg <= x_in - dx;
            y_reg <= y_in + dy;
            z_reg <= z_in - ATAN;
        end
        else
        begin
            x_reg <= x_in + dx;
            y_reg <= y_in - dy;
            z_reg <= z_in + ATAN;
        end
        zero_reg <= zero_in;
    end
endmodule

/* rtl/quaternion_to_roll_pitch.sv */
// Top level: quaternion (Q2.14) to roll (Q3.13) and pitch (Q2.13) via pipelined CORDIC.
// Depends on qrp_pkg, qrp_sqrt_cell, qrp_cordic_cell, assert_macros.svh.
//
//  channel | signals                    | handshake
//  --------+----------------------------+--------------------------------
//  command | q_w q_x q_y q_z            | start, taken when busy is low
//  result  | roll pitch                 | done, one-cycle strobe
//
// One quaternion per clock; busy never rises. Stages in order: input,
// products, sums, s^2 and pre-rotation, 29 square-root digit cells, then
// the pitch CORDIC cells and the output register. Roll runs its CORDIC
// beside the root and waits in a delay line. Reset clears only the valid
// line; results cannot stall.
`include "assert_macros.svh"
module quaternion_to_roll_pitch #(
    parameter int CORDIC_STEPS = qrp_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = qrp_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] q_w,
    input  logic signed [15:0] q_x,
    input  logic signed [15:0] q_y,
    input  logic signed [15:0] q_z,
    output logic               done,
    output logic signed [15:0] roll,
    output logic signed [14:0] pitch
);
    localparam int VW    = qrp_pkg::VEC_W;
    localparam int ANG_W = FRAC_BITS + 4;
    localparam int OW    = ANG_W + 4;
    localparam int NS    = qrp_pkg::SQRT_STEPS;
    localparam int LAT   = 34 + CORDIC_STEPS;
    localparam int SH_R  = (FRAC_BITS > qrp_pkg::OUT_FRAC) ? FRAC_BITS - qrp_pkg::OUT_FRAC : 0;
    localparam int SH_L  = (FRAC_BITS < qrp_pkg::OUT_FRAC) ? qrp_pkg::OUT_FRAC - FRAC_BITS : 0;
    localparam logic signed [OW-1:0] RND      = (SH_R > 0) ? OW'(1) <<< (SH_R - 1) : '0;
    localparam logic signed [OW-1:0] ROLL_LIM = OW'(qrp_pkg::ROLL_MAX);
    localparam logic signed [OW-1:0] PITCH_LIM = OW'(qrp_pkg::PITCH_MAX);
    localparam logic signed [63:0] HALF_PI_64 =
        qrp_pkg::round_q60(qrp_pkg::PI_QUARTER_Q60 * 2, FRAC_BITS);
    localparam logic signed [ANG_W-1:0] HALF_PI = HALF_PI_64[ANG_W-1:0];
    localparam logic signed [qrp_pkg::S_W-1:0] ONE_S = qrp_pkg::S_W'(1) <<< 28;

    function automatic logic signed [15:0] to_out(input logic signed [ANG_W-1:0] z,
                                                  input logic signed [OW-1:0] lim);
        logic signed [OW-1:0] t;
        t = ((OW'(z) + RND) >>> SH_R) <<< SH_L;
        if (t > lim) t = lim;
        if (t < -lim) t = -lim;
        return t[15:0];
    endfunction

    logic [LAT-1:0] vld_reg;

    logic signed [15:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [31:0] wx_reg, yz_reg, ww_reg, zz_reg, xx_reg, yy_reg, wy_reg, xz_reg;
    logic signed [33:0] num_reg;
    logic signed [32:0] den_reg;
    logic signed [33:0] s_full;
    logic signed [qrp_pkg::S_W-1:0] s_reg, s_d_reg;
    logic signed [59:0] ss;
    logic [qrp_pkg::SQ_W-1:0] rad_reg;

    logic signed [VW-1:0]    px_next, py_next;
    logic signed [ANG_W-1:0] pz_next;
    logic                    zero_next;

    logic signed [VW-1:0]    rx [0:CORDIC_STEPS];
    logic signed [VW-1:0]    ry [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] rz [0:CORDIC_STEPS];
    logic                    rzero [0:CORDIC_STEPS];

    logic signed [VW-1:0]    tx [0:CORDIC_STEPS];
    logic signed [VW-1:0]    ty [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] tz [0:CORDIC_STEPS];
    logic                    tzero [0:CORDIC_STEPS];

    logic [qrp_pkg::SQ_W-1:0]       rem [0:NS];
    logic [NS-1:0]                  root [0:NS];
    logic signed [qrp_pkg::S_W-1:0] sa [0:NS];

    logic signed [15:0] roll_cv;
    logic signed [15:0] roll_dly_reg [0:NS-1];
    logic signed [15:0] pitch_cv;

    assign busy = 1'b0;
    assign done = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
    end

    assign s_full = (35'(wy_reg) - 35'(xz_reg)) <<< 1 > 0 ? 34'(((35'(wy_reg) - 35'(xz_reg))) <<< 1)
                  : 34'(((35'(wy_reg) - 35'(xz_reg))) <<< 1);
    assign ss = 60'(s_reg) * 60'(s_reg);

    // pre-rotate roll vector into the right half plane
    always_comb
    begin
        px_next   = VW'(den_reg);
        py_next   = VW'(num_reg);
        pz_next   = '0;
        zero_next = (num_reg == '0) && (den_reg == '0);
        if (den_reg[32])
        begin
            if (!num_reg[33])
            begin
                px_next = VW'(num_reg);
                py_next = -VW'(den_reg);
                pz_next = HALF_PI;
            end
            else
            begin
                px_next = -VW'(num_reg);
                py_next = VW'(den_reg);
                pz_next = -HALF_PI;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start & ~busy)
        begin
            w_reg <= q_w;
            x_reg <= q_x;
            y_reg <= q_y;
            z_reg <= q_z;
        end
        wx_reg <= w_reg * x_reg;
        yz_reg <= y_reg * z_reg;
        ww_reg <= w_reg * w_reg;
        zz_reg <= z_reg * z_reg;
        xx_reg <= x_reg * x_reg;
        yy_reg <= y_reg * y_reg;
        wy_reg <= w_reg * y_reg;
        xz_reg <= x_reg * z_reg;

        num_reg <= (34'(wx_reg) + 34'(yz_reg)) <<< 1;
        den_reg <= 33'(ww_reg) + 33'(zz_reg) - 33'(xx_reg) - 33'(yy_reg);
        // saturate asin argument to +-1
        if (s_full > 34'(ONE_S))
            s_reg <= ONE_S;
        else if (s_full < -34'(ONE_S))
            s_reg <= -ONE_S;
        else
            s_reg <= s_full[qrp_pkg::S_W-1:0];

        rad_reg  <= (qrp_pkg::SQ_W'(1) << 56) - ss[qrp_pkg::SQ_W-1:0];
        s_d_reg  <= s_reg;
        rx[0]    <= px_next;
        ry[0]    <= py_next;
        rz[0]    <= pz_next;
        rzero[0] <= zero_next;
    end

    assign rem[0]  = rad_reg;
    assign root[0] = '0;
    assign sa[0]   = s_d_reg;

    for (genvar j = 0; j < NS; j++) begin : g_sqrt
        qrp_sqrt_cell #(
            .BIT (NS - 1 - j)
        ) u_cell (
            .clk      (clk),
            .rem_in   (rem[j]),
            .root_in  (root[j]),
            .s_in     (sa[j]),
            .rem_reg  (rem[j+1]),
            .root_reg (root[j+1]),
            .s_reg    (sa[j+1])
        );
    end

    assign tx[0]    = VW'(root[NS]);
    assign ty[0]    = VW'(sa[NS]);
    assign tz[0]    = '0;
    assign tzero[0] = (root[NS] == '0) && (sa[NS] == '0);

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        qrp_cordic_cell #(
            .ANG_W    (ANG_W),
            .SHIFT    (k),
            .ATAN_VAL (qrp_pkg::round_q60(qrp_pkg::atan_q60(k), FRAC_BITS))
        ) u_roll (
            .clk      (clk),
            .x_in     (rx[k]),
            .y_in     (ry[k]),
            .z_in     (rz[k]),
            .zero_in  (rzero[k]),
            .x_reg    (rx[k+1]),
            .y_reg    (ry[k+1]),
            .z_reg    (rz[k+1]),
            .zero_reg (rzero[k+1])
        );
        qrp_cordic_cell #(
            .ANG_W    (ANG_W),
            .SHIFT    (k),
            .ATAN_VAL (qrp_pkg::round_q60(qrp_pkg::atan_q60(k), FRAC_BITS))
        ) u_pitch (
            .clk      (clk),
            .x_in     (tx[k]),
            .y_in     (ty[k]),
            .z_in     (tz[k]),
            .zero_in  (tzero[k]),
            .x_reg    (tx[k+1]),
            .y_reg    (ty[k+1]),
            .z_reg    (tz[k+1]),
            .zero_reg (tzero[k+1])
        );
    end

    assign roll_cv  = rzero[CORDIC_STEPS] ? '0 : to_out(rz[CORDIC_STEPS], ROLL_LIM);
    assign pitch_cv = tzero[CORDIC_STEPS] ? '0 : to_out(tz[CORDIC_STEPS], PITCH_LIM);

    // hold roll while the pitch root finishes
    always_ff @(posedge clk)
    begin
        roll_dly_reg[0] <= roll_cv;
        for (int d = 1; d < NS; d++)
            roll_dly_reg[d] <= roll_dly_reg[d-1];
        roll  <= roll_dly_reg[NS-1];
        pitch <= pitch_cv[14:0];
    end

    `ASSERT_AFTER(a_latency, clk, rst_n, start && !busy, LAT, done)
    `ASSERT_IMPL(a_roll_range, clk, rst_n, done, (roll <= 16'sd25736) && (roll >= -16'sd25736))
    `ASSERT_IMPL(a_pitch_range, clk, rst_n, done, (pitch <= 15'sd12868) && (pitch >= -15'sd12868))

endmodule

/* sim/qrp_checker.sv */
// Checker for quaternion_to_roll_pitch: watches accepted commands, predicts roll and pitch
// with a local CORDIC and root model, and compares each done beat in order.
// Depends on nothing but the block's port widths.
module qrp_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] q_w,
    input  logic signed [15:0] q_x,
    input  logic signed [15:0] q_y,
    input  logic signed [15:0] q_z,
    input  logic               done,
    input  logic signed [15:0] roll,
    input  logic signed [14:0] pitch,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 16;
    localparam int FB = 14;
    localparam longint ROLL_LIM = 25736;
    localparam longint PITCH_LIM = 12868;
    localparam longint PI_Q60_QTR = 64'sh0C90FDAA22168C23;
    localparam longint ONE28 = 64'sd1 <<< 28;

    typedef struct packed {
        logic signed [15:0] r;
        logic signed [14:0] p;
    } angles_t;

    angles_t expected_angles[$];
    longint atan_lut[STEPS];
    longint half_pi;

    function automatic longint round_to_fb(longint v);
        return (v + (64'sd1 <<< (59 - FB))) >>> (60 - FB);
    endfunction

    function automatic longint atan_series(int i);
        longint acc;
        longint t;
        int e;
        acc = 0;
        if (i == 0) return PI_Q60_QTR;
        for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e > 60) break;
            t = longint'((64'd1 << (60 - e)) / longint'(2 * k + 1));
            acc = (k % 2) ? acc - t : acc + t;
        end
        return acc;
    endfunction

    function automatic longint cordic_angle(longint yv, longint xv);
        longint za;
        longint t;
        longint dx;
        longint dy;
        za = 0;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0) begin
            t = xv;
            if (yv >= 0) begin
                xv = yv;
                yv = -t;
                za = half_pi;
            end else begin
                xv = -yv;
                yv = t;
                za = -half_pi;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv < 0) begin
                xv -= dx;
                yv += dy;
                za -= atan_lut[i];
            end else begin
                xv += dx;
                yv -= dy;
                za += atan_lut[i];
            end
        end
        return za;
    endfunction

    function automatic longint int_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint scale_clamp(longint za, longint lim);
        za = (za + 1) >>> (FB - 13);
        if (za > lim) za = lim;
        if (za < -lim) za = -lim;
        return za;
    endfunction

    function automatic angles_t predict_angles(longint w, longint x, longint y, longint z);
        longint num;
        longint den;
        longint s;
        longint c;
        angles_t a;
        num = 2 * (w * x + y * z);
        den = w * w + z * z - x * x - y * y;
        s = 2 * (w * y - x * z);
        if (s > ONE28) s = ONE28;
        if (s < -ONE28) s = -ONE28;
        c = int_root(longint'(ONE28 * ONE28 - s * s));
        a.r = 16'(scale_clamp(cordic_angle(num, den), ROLL_LIM));
        a.p = 15'(scale_clamp(cordic_angle(s, c), PITCH_LIM));
        return a;
    endfunction

    initial
    begin
        for (int i = 0; i < STEPS; i++) atan_lut[i] = round_to_fb(atan_series(i));
        half_pi = round_to_fb(PI_Q60_QTR * 2);
        errors = 0;
    end

    assign pending = expected_angles.size();

    always @(posedge clk)
    begin
        angles_t e;
        if (rst_n) begin
            if (done) begin
                if (expected_angles.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    e = expected_angles.pop_front();
                    if (roll !== e.r) begin
                        $error("roll expected %0d actual %0d", e.r, roll);
                        errors++;
                    end
                    if (pitch !== e.p) begin
                        $error("pitch expected %0d actual %0d", e.p, pitch);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                expected_angles.push_back(predict_angles(q_w, q_x, q_y, q_z));
        end
    end
endmodule

/* sim/quaternion_to_roll_pitch_tb.sv */
// Testbench top for quaternion_to_roll_pitch, gives the verdict: drives directed and
// random quaternions, most with random gaps. Depends on qrp_checker and the block.
module quaternion_to_roll_pitch_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic signed [15:0] q_w = 0, q_x = 0, q_y = 0, q_z = 0;
    logic done;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    int errors;
    int pending;

    quaternion_to_roll_pitch dut (.*);
    qrp_checker chk (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    function automatic logic [15:0] rand_word(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 32767) - 16384 + 16384 * 0);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // hold one beat until accepted; when gaps is set, may idle first at random
    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, bit gaps);
        if (gaps && $urandom_range(0, 99) < 16) begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        q_w <= w;
        q_x <= x;
        q_y <= y;
        q_z <= z;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    initial
    begin
        int unit_norm;
        logic [15:0] w, x, y, z;
        real a, b, c, d, n;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // extremes, zero vector, saturated asin, pure axes, sign cases
        send_quat(0, 0, 0, 0, 0);
        send_quat(16384, 0, 0, 0, 0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);
        send_quat(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0);
        send_quat(0, 16384, 0, 0, 0);
        send_quat(0, 0, 16384, 0, 0);
        send_quat(0, 0, 0, 16384, 0);
        send_quat(11585, 11585, 0, 0, 0);
        send_quat(11585, 0, 11585, 0, 0);
        send_quat(11585, 0, 16'(-11585), 0, 0);
        send_quat(11585, 16'(-11585), 0, 0, 0);
        send_quat(0, 16'(-16384), 0, 0, 0);
        send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001, 0);
        send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0);
        send_quat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 0);
        send_quat(12000, 12000, 12000, 12000, 0);
        send_quat(8192, 8192, 8192, 8192, 0);
        for (int i = 0; i < 1300; i++) begin
            unit_norm = $urandom_range(0, 99);
            if (unit_norm < 70) begin
                a = $itor($signed($urandom_range(0, 2000))) - 1000.0;
                b = $itor($signed($urandom_range(0, 2000))) - 1000.0;
                c = $itor($signed($urandom_range(0, 2000))) - 1000.0;
                d = $itor($signed($urandom_range(0, 2000))) - 1000.0;
                n = $sqrt(a * a + b * b + c * c + d * d) + 1.0e-9;
                w = 16'($rtoi(16384.0 * a / n));
                x = 16'($rtoi(16384.0 * b / n));
                y = 16'($rtoi(16384.0 * c / n));
                z = 16'($rtoi(16384.0 * d / n));
            end else begin
                w = rand_word(unit_norm % 3);
                x = rand_word(0);
                y = rand_word(unit_norm % 2);
                z = rand_word(0);
            end
            send_quat(w, x, y, z, !(i >= 400 && i < 600));
        end
        start <= 0;
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("PASS quaternion_to_roll_pitch");
        else
            $display("FAIL quaternion_to_roll_pitch");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("FAIL quaternion_to_roll_pitch");
        $finish;
    end
endmodule

/* quaternion_to_roll_pitch.f */
+incdir+rtl
rtl/qrp_pkg.sv
rtl/qrp_sqrt_cell.sv
rtl/qrp_cordic_cell.sv
rtl/quaternion_to_roll_pitch.sv
sim/qrp_checker.sv
sim/quaternion_to_roll_pitch_tb.sv
